>>> design/lru_stack_distance_macros.svh
// Assertion macros shared by the LRU stack-distance modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef LRU_STACK_DISTANCE_MACROS_SVH
`define LRU_STACK_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_stack_distance assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_stack_distance assertion failed");

`endif

>>> design/lsd_pkg.sv
// Package for the LRU stack-distance block: sizes, datapath operations and
// the command and status structs between controller and datapath. No dependencies.
package lsd_pkg;

   localparam int PAGE_W      = 52;
   localparam int DEPTH_W     = 6;
   localparam int CAP_W       = 7;
   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SEARCH_RD,
      OP_NEXT,
      OP_HIT,
      OP_MISS,
      OP_SHIFT_RD,
      OP_SHIFT_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      write_top;
      logic      cap_we;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
      logic match;
      logic idx_zero;
   } dp_status_type;

endpackage

>>> design/lru_stack_distance.sv
// Top level of the LRU stack-distance block: controller plus datapath.
// Depends on lsd_pkg, lsd_controller, lsd_datapath and lsd_ram.
//
// Usage: present a page number on req_page_number and raise start; the
// reference is taken at a rising edge where start is high and busy is low.
// One result beat follows per reference: rsp_valid is high for exactly one
// cycle with rsp_hit and rsp_depth (distance from the most recent end on a
// hit, 0 on a miss). The receiver cannot stall, so the beat must be taken.
// Capacity is written through csr_valid/csr_ready/csr_capacity; csr_ready is
// high only while the block is idle, and capacity 0 acts as 1.
// The stack sits in one RAM with a registered read port, so each entry
// searched takes a read state and a compare state, and each entry shifted
// takes a read state and a write state. A new reference may be accepted in
// the cycle of the beat.
// Reset empties the stack (count zero, no clearing pass needed) and sets the
// capacity to 64.
module lru_stack_distance (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lsd_pkg::PAGE_W-1:0]   req_page_number,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [lsd_pkg::DEPTH_W-1:0]  rsp_depth,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lsd_pkg::CAP_W-1:0]    csr_capacity
);
   import lsd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lsd_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .cmd      (cmd),
      .status   (status)
   );

   lsd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_page_number(req_page_number),
      .csr_capacity   (csr_capacity),
      .rsp_hit        (rsp_hit),
      .rsp_depth      (rsp_depth)
   );

endmodule

>>> design/lsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/lsd_datapath.sv
// Datapath of the LRU stack-distance block: stack RAM, page and index
// registers, entry count and capacity. Depends on lsd_pkg and lsd_ram.
`include "lru_stack_distance_macros.svh"

module lsd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lsd_pkg::dp_cmd_type          cmd,
   output lsd_pkg::dp_status_type       status,
   input  logic [lsd_pkg::PAGE_W-1:0]   req_page_number,
   input  logic [lsd_pkg::CAP_W-1:0]    csr_capacity,
   output logic                         rsp_hit,
   output logic [lsd_pkg::DEPTH_W-1:0]  rsp_depth
);
   import lsd_pkg::*;

   logic [PAGE_W-1:0] page_ff, page_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, idx_dec;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  found_ff, found_in;
   logic [EXT_W-1:0]  cap_ext;
   logic [CNT_W-1:0]  eff_cap, new_count;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [PAGE_W-1:0] ram_wdata, ram_rdata;

   lsd_ram #(
      .WIDTH(PAGE_W),
      .DEPTH(MAX_ENTRIES)
   ) u_stack_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign cap_ext = EXT_W'(cap_ff);
   assign idx_dec = idx_ff - 1'b1;

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_ext > EXT_W'(MAX_ENTRIES)) begin
         eff_cap = CNT_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ext);
      end
   end

   assign new_count = (count_ff < eff_cap) ? count_ff + 1'b1 : eff_cap;

   always_comb begin
      page_in   = page_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      cap_in    = cmd.cap_we ? csr_capacity : cap_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[IDX_W-1:0];
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[IDX_W-1:0];
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            page_in  = req_page_number;
            idx_in   = '0;
            hit_in   = 1'b0;
            found_in = '0;
         end
         OP_SEARCH_RD: begin
            ram_re = 1'b1;
         end
         OP_NEXT: begin
            idx_in = idx_ff + 1'b1;
         end
         OP_HIT: begin
            hit_in   = 1'b1;
            found_in = idx_ff[IDX_W-1:0];
         end
         OP_MISS: begin
            count_in = new_count;
            idx_in   = new_count - 1'b1;
         end
         OP_SHIFT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_dec[IDX_W-1:0];
         end
         OP_SHIFT_WR: begin
            ram_we = 1'b1;
            idx_in = idx_dec;
         end
         default: begin
         end
      endcase
      if (cmd.write_top) begin
         ram_we    = 1'b1;
         ram_waddr = '0;
         ram_wdata = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
   end

   assign status.search_done = (idx_ff == count_ff);
   assign status.match       = (ram_rdata == page_ff);
   assign status.idx_zero    = (idx_ff == '0);

   assign rsp_hit   = hit_ff;
   assign rsp_depth = DEPTH_W'(found_ff);

   `LSD_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `LSD_ASSERT_NEXT(a_miss_count_nonzero, clock, reset, cmd.op == OP_MISS, count_ff != '0)

endmodule

>>> design/lsd_controller.sv
// Controller of the LRU stack-distance block: sequences search, shift and
// result beat, and gates configuration writes. Depends on lsd_pkg.
`include "lru_stack_distance_macros.svh"

module lsd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   output lsd_pkg::dp_cmd_type     cmd,
   input  lsd_pkg::dp_status_type  status
);
   import lsd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_SHIFT,
      S_SHIFT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      cmd.op        = OP_NONE;
      cmd.write_top = 1'b0;
      cmd.cap_we    = csr_valid && (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (status.search_done) begin
               cmd.op   = OP_MISS;
               state_in = S_SHIFT;
            end else begin
               cmd.op   = OP_SEARCH_RD;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (status.match) begin
               cmd.op   = OP_HIT;
               state_in = S_SHIFT;
            end else begin
               cmd.op   = OP_NEXT;
               state_in = S_SEARCH;
            end
         end
         S_SHIFT: begin
            if (status.idx_zero) begin
               cmd.write_top = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.op   = OP_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.op   = OP_SHIFT_WR;
            state_in = S_SHIFT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `LSD_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `LSD_ASSERT_NEXT(a_start_search, clock, reset, (state_ff == S_IDLE) && start, state_ff == S_SEARCH)
   `LSD_ASSERT_NEXT(a_done_beat, clock, reset, (state_ff == S_SHIFT) && status.idx_zero, rsp_valid_ff && (state_ff == S_IDLE))
   `LSD_ASSERT_IMPL(a_beat_idle, clock, reset, rsp_valid_ff, !busy)

endmodule
